// File: design/nles_pkg.sv
// Shared types and constants for the normal-line nearest edge selector.
package nles_pkg;

  localparam int CFG_INDEX_BITS = 3;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  // Configuration register indexes
  localparam cfg_index_t REG_CENTRE_X    = cfg_index_t'(0);
  localparam cfg_index_t REG_CENTRE_Y    = cfg_index_t'(1);
  localparam cfg_index_t REG_NORMAL_X    = cfg_index_t'(2);
  localparam cfg_index_t REG_NORMAL_Y    = cfg_index_t'(3);
  localparam cfg_index_t REG_MAX_DIST    = cfg_index_t'(4);
  localparam cfg_index_t REG_CROSS_LIMIT = cfg_index_t'(5);

  // Reset distance limit in pixels; the limit register holds its square
  localparam int MAX_DIST_RESET = 16;

  // Control travelling with the product stage
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

// File: design/normal_line_nearest_edge_select.sv
// Top level of the normal-line nearest edge selector.
// Picks, from a run of edge pixels, the point nearest a configured centre that
// lies on the line through it along a configured unit normal (signed Q2.14 by
// default). Each pixel's offset from the centre gives a squared distance; a
// pixel is a candidate when that distance does not exceed the running limit
// (reset and end of run: max_dist squared) and |normal x offset| is strictly
// below the cross-product threshold. A candidate becomes the kept point and its
// squared distance the new limit, so an equal-distance later pixel replaces an
// earlier one.
// The pixel marked by tlast is judged the same way, then one result goes out:
// the kept point with found set, or zeros with found clear, and the run state
// clears. Throughput is one pixel per clock; the result passes the input
// register, product register and result register after the tlast transfer.
// The only feedback is the running limit, which is compared and updated in the
// same cycle, so pixels stream back to back. Input stalls only when a finished
// result still waits and another run end reaches the compare stage. Configuration
// must be written only while the block is idle; the block does not enforce it.
// A max_dist write reloads the running limit when no pixel is being taken.
module normal_line_nearest_edge_select #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // slave side: edge pixels
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]         s_tdata,  // edge_x, edge_y, zero pad
  input  logic                                      s_tlast,  // last_point
  // master side: selected point
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [((2*COORD_BITS+7)/8)*8-1:0]         m_tdata,  // best_x, best_y, zero pad
  output logic [0:0]                                m_tuser,  // found
  // configuration writes
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  nles_pkg::cfg_index_t                      cfg_index,
  input  logic [COORD_BITS+FRAC_BITS:0]             cfg_data
);
  import nles_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int DW   = ((2*COORD_BITS+7)/8)*8;
  localparam int CW   = COORD_BITS + FRAC_BITS + 3;

  logic [CB-1:0]               centre_x;
  logic [CB-1:0]               centre_y;
  logic signed [FRAC_BITS+1:0] normal_x;
  logic signed [FRAC_BITS+1:0] normal_y;
  logic [CB+FRAC_BITS:0]       cross_limit;
  logic [2*CB-1:0]             limit_init;
  logic                        limit_reload;

  stage_ctl_t                  stg;
  logic [CB-1:0]               stg_x;
  logic [CB-1:0]               stg_y;
  logic [2*CB:0]               stg_d2;
  logic signed [CW-1:0]        stg_cross;
  logic                        take;

  logic [CB-1:0]               best_x;
  logic [CB-1:0]               best_y;
  logic                        found;

  nles_cfg #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .centre_x     (centre_x),
    .centre_y     (centre_y),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .cross_limit  (cross_limit),
    .limit_init   (limit_init),
    .limit_reload (limit_reload)
  );

  nles_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .edge_x    (s_tdata[CB-1:0]),
    .edge_y    (s_tdata[2*CB-1:CB]),
    .in_last   (s_tlast),
    .centre_x  (centre_x),
    .centre_y  (centre_y),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .take      (take),
    .stg       (stg),
    .stg_x     (stg_x),
    .stg_y     (stg_y),
    .stg_d2    (stg_d2),
    .stg_cross (stg_cross)
  );

  nles_select #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_select (
    .clk          (clk),
    .rst          (rst),
    .stg          (stg),
    .stg_x        (stg_x),
    .stg_y        (stg_y),
    .stg_d2       (stg_d2),
    .stg_cross    (stg_cross),
    .cross_limit  (cross_limit),
    .limit_init   (limit_init),
    .limit_reload (limit_reload),
    .take         (take),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .best_x       (best_x),
    .best_y       (best_y),
    .found        (found)
  );

  assign m_tdata = DW'({best_y, best_x});
  assign m_tuser = found;

endmodule

// File: design/nles_cfg.sv
// Configuration register file with precomputed squared distance limit.
module nles_cfg #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  nles_pkg::cfg_index_t            cfg_index,
  input  logic [COORD_BITS+FRAC_BITS:0]   cfg_data,
  output logic [COORD_BITS-1:0]           centre_x,
  output logic [COORD_BITS-1:0]           centre_y,
  output logic signed [FRAC_BITS+1:0]     normal_x,
  output logic signed [FRAC_BITS+1:0]     normal_y,
  output logic [COORD_BITS+FRAC_BITS:0]   cross_limit,
  output logic [2*COORD_BITS-1:0]         limit_init,
  output logic                            limit_reload
);
  import nles_pkg::*;

  localparam int NB = FRAC_BITS + 2;
  localparam int EB = COORD_BITS + FRAC_BITS + 1;
  localparam int LB = 2 * COORD_BITS;
  localparam logic signed [NB-1:0] NormalUnit = NB'(2 ** FRAC_BITS);
  localparam logic [EB-1:0]        EpsReset   = EB'(2 ** FRAC_BITS);
  localparam logic [LB-1:0]        LimitReset = LB'(MAX_DIST_RESET * MAX_DIST_RESET);

  logic [LB-1:0] md_wide;
  logic [LB-1:0] md_sq;

  assign cfg_ready = 1'b1;
  assign md_wide   = LB'(cfg_data[COORD_BITS-1:0]);
  assign md_sq     = md_wide * md_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x     <= '0;
      centre_y     <= '0;
      normal_x     <= NormalUnit;
      normal_y     <= '0;
      cross_limit  <= EpsReset;
      limit_init   <= LimitReset;
      limit_reload <= 1'b0;
    end else begin
      limit_reload <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CENTRE_X:  centre_x  <= cfg_data[COORD_BITS-1:0];
          REG_CENTRE_Y:  centre_y  <= cfg_data[COORD_BITS-1:0];
          REG_NORMAL_X:  normal_x  <= $signed(cfg_data[NB-1:0]);
          REG_NORMAL_Y:  normal_y  <= $signed(cfg_data[NB-1:0]);
          REG_MAX_DIST: begin
            limit_init   <= md_sq;
            limit_reload <= 1'b1;
          end
          REG_CROSS_LIMIT: cross_limit <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: design/nles_front.sv
// Input register and product stage: offset, squared distance, cross product.
module nles_front #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [COORD_BITS-1:0]                 edge_x,
  input  logic [COORD_BITS-1:0]                 edge_y,
  input  logic                                  in_last,
  input  logic [COORD_BITS-1:0]                 centre_x,
  input  logic [COORD_BITS-1:0]                 centre_y,
  input  logic signed [FRAC_BITS+1:0]           normal_x,
  input  logic signed [FRAC_BITS+1:0]           normal_y,
  input  logic                                  take,
  output nles_pkg::stage_ctl_t                  stg,
  output logic [COORD_BITS-1:0]                 stg_x,
  output logic [COORD_BITS-1:0]                 stg_y,
  output logic [2*COORD_BITS:0]                 stg_d2,
  output logic signed [COORD_BITS+FRAC_BITS+2:0] stg_cross
);
  import nles_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int CW = COORD_BITS + FRAC_BITS + 3;

  logic                 s1_valid;
  logic                 s1_last;
  logic [CB-1:0]        s1_x;
  logic [CB-1:0]        s1_y;
  logic                 adv2;
  logic signed [CB:0]   dx;
  logic signed [CB:0]   dy;
  logic signed [2*CB+1:0] dx_sq;
  logic signed [2*CB+1:0] dy_sq;
  logic [2*CB:0]        d2;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;

  assign adv2     = !stg.valid || take;
  assign in_ready = !s1_valid || adv2;

  assign dx    = $signed({1'b0, s1_x}) - $signed({1'b0, centre_x});
  assign dy    = $signed({1'b0, s1_y}) - $signed({1'b0, centre_y});
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  // each square is below 2^(2*CB), so the low bits carry it exactly
  assign d2    = {1'b0, dx_sq[2*CB-1:0]} + {1'b0, dy_sq[2*CB-1:0]};
  assign px    = normal_x * dy;
  assign py    = normal_y * dx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_x    <= edge_x;
      s1_y    <= edge_y;
      s1_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg.valid <= 1'b0;
    end else if (adv2) begin
      stg.valid <= s1_valid;
      if (s1_valid) begin
        stg.last <= s1_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      stg_x     <= s1_x;
      stg_y     <= s1_y;
      stg_d2    <= d2;
      stg_cross <= px - py;
    end
  end

endmodule

// File: design/nles_select.sv
// Running-limit compare, kept-point state and result register.
module nles_select #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  nles_pkg::stage_ctl_t                  stg,
  input  logic [COORD_BITS-1:0]                 stg_x,
  input  logic [COORD_BITS-1:0]                 stg_y,
  input  logic [2*COORD_BITS:0]                 stg_d2,
  input  logic signed [COORD_BITS+FRAC_BITS+2:0] stg_cross,
  input  logic [COORD_BITS+FRAC_BITS:0]         cross_limit,
  input  logic [2*COORD_BITS-1:0]               limit_init,
  input  logic                                  limit_reload,
  output logic                                  take,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [COORD_BITS-1:0]                 best_x,
  output logic [COORD_BITS-1:0]                 best_y,
  output logic                                  found
);
  import nles_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int CW = COORD_BITS + FRAC_BITS + 3;
  localparam logic [2*CB-1:0] LimitReset = (2*CB)'(MAX_DIST_RESET * MAX_DIST_RESET);

  logic [CB-1:0]   kept_x;
  logic [CB-1:0]   kept_y;
  logic            have_point;
  logic [2*CB-1:0] dist_limit;
  logic [CW-1:0]   mag;
  logic            hit;
  logic [CB-1:0]   new_x;
  logic [CB-1:0]   new_y;

  assign mag   = stg_cross[CW-1] ? CW'(-stg_cross) : CW'(stg_cross);
  // ties on distance go to the later point
  assign hit   = ({1'b0, dist_limit} >= stg_d2) && (mag < {2'b00, cross_limit});
  assign new_x = hit ? stg_x : kept_x;
  assign new_y = hit ? stg_y : kept_y;
  // a run end may only move on once the result register has room
  assign take  = stg.valid && !(stg.last && out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_x     <= '0;
      kept_y     <= '0;
      have_point <= 1'b0;
      dist_limit <= LimitReset;
    end else if (take) begin
      if (stg.last) begin
        kept_x     <= '0;
        kept_y     <= '0;
        have_point <= 1'b0;
        dist_limit <= limit_init;
      end else if (hit) begin
        kept_x     <= stg_x;
        kept_y     <= stg_y;
        have_point <= 1'b1;
        dist_limit <= stg_d2[2*CB-1:0];
      end
    end else if (limit_reload) begin
      dist_limit <= limit_init;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && stg.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // kept point is zero whenever nothing is held, so no extra gating is needed
  always_ff @(posedge clk) begin
    if (take && stg.last) begin
      best_x <= new_x;
      best_y <= new_y;
      found  <= hit || have_point;
    end
  end

endmodule

// File: design/nles_checker.sv
// Port-level checks for the normal-line nearest edge selector, bound to the top.
module nles_checker #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
  input logic [0:0]                        m_tuser,
  input logic                              cfg_ready
);

  // no result transaction can be pending right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an empty run reports an all-zero point
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("found clear with nonzero point");

  // configuration writes are never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config channel not ready");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

endmodule

bind normal_line_nearest_edge_select nles_checker #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_nles_checker (.*);
